[src/fifo_auth_cache_with_ttl_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the authorisation cache
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_AUTH_CACHE_WITH_TTL_TOP_ASSERT_SVH
`define FIFO_AUTH_CACHE_WITH_TTL_TOP_ASSERT_SVH

// same-cycle implication
`define FATC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FATC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/fatc_pkg.sv]
// ----------------------------------------------------------------------------
// fatc_pkg
// Types and constants shared by the authorisation cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fatc_pkg;

	localparam int unsigned GROUP = 8;

	localparam logic [31:0] TTL_RESET = 32'd5400;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic [31:0] bank;
		logic [63:0] acct;
	} key_t;

	typedef struct packed {
		key_t key;
		logic verdict;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic clear;
		logic cmp;
	} ctrl_t;

endpackage

`default_nettype wire

[src/fifo_auth_cache_with_ttl_top.sv]
// Group matches are registered on accept, the result once the output is free (delayed by out_stall).
// in_stall is high from each accept until its result is registered, so one item is taken at a time.
// On accept a lookup compares all entries or an insert shifts the cell row; then the first match resolves.
// Reset: entries, timestamp and output valid clear; the TTL register returns to 5400.
// No clearing pass after reset; items accepted from the first cycle.
// ----------------------------------------------------------------------------
// fifo_auth_cache_with_ttl_top
// Single-bucket authorisation cache with FIFO eviction and bucket TTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_auth_cache_with_ttl_top #(
	parameter  int unsigned ENTRIES = 100,
	localparam int unsigned NGRP    = (ENTRIES + fatc_pkg::GROUP - 1) / fatc_pkg::GROUP
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        cmd,
	input  wire [31:0] bank_code,
	input  wire [63:0] account_number,
	input  wire        verdict_in,
	input  wire [31:0] now_seconds,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       hit,
	output logic       verdict_out,
	output logic       was_expired,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [31:0] ttl_seconds
);

	logic [31:0]      ttl_q;
	logic [31:0]      last_q;
	logic             busy_q;
	logic             out_valid_q;
	logic             cmd_q;
	logic             vin_q;
	logic [31:0]      now_q;
	logic             exp_q;
	logic             hit_q;
	logic             vout_q;
	logic             wexp_q;

	logic             accept;
	logic             finish;
	logic [31:0]      age;
	logic             expired;
	logic             found;
	logic             found_vd;
	fatc_pkg::ctrl_t  ctrl;
	fatc_pkg::entry_t new_ent;
	fatc_pkg::key_t   key;
	logic [NGRP-1:0]  grp_hit_q;
	logic [NGRP-1:0]  grp_vd_q;

	assign in_stall  = busy_q;
	assign cfg_ready = !busy_q;
	assign accept    = in_valid && !busy_q;
	assign finish    = busy_q && (!out_valid_q || !out_stall);

	assign age     = now_seconds - last_q;
	assign expired = (last_q == '0) || (age > ttl_q);

	assign key.bank        = bank_code;
	assign key.acct        = account_number;
	assign new_ent.key     = key;
	assign new_ent.verdict = verdict_in;

	assign ctrl.load  = accept;
	assign ctrl.shift = accept && (cmd == fatc_pkg::CMD_INSERT);
	assign ctrl.clear = accept && (cmd == fatc_pkg::CMD_INSERT) && expired;
	assign ctrl.cmp   = accept && (cmd == fatc_pkg::CMD_LOOKUP) && !expired;

	fatc_chain #(.ENTRIES(ENTRIES)) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_ent  (new_ent),
		.key      (key),
		.grp_hit_q(grp_hit_q),
		.grp_vd_q (grp_vd_q)
	);

	always_comb begin
		found    = 1'b0;
		found_vd = 1'b0;
		for (int g = int'(NGRP) - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				found    = 1'b1;
				found_vd = grp_vd_q[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q       <= fatc_pkg::TTL_RESET;
			last_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				ttl_q <= ttl_seconds;
			end
			if (accept) begin
				busy_q <= 1'b1;
				if (cmd == fatc_pkg::CMD_INSERT) begin
					last_q <= now_seconds;
				end
			end else if (finish) begin
				busy_q <= 1'b0;
				if ((cmd_q == fatc_pkg::CMD_LOOKUP) && found) begin
					last_q <= now_q;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			vin_q <= verdict_in;
			now_q <= now_seconds;
			exp_q <= expired;
		end
		if (finish) begin
			wexp_q <= exp_q;
			unique case (cmd_q)
				fatc_pkg::CMD_INSERT: begin
					hit_q  <= 1'b0;
					vout_q <= vin_q;
				end
				default: begin
					hit_q  <= found;
					vout_q <= found && found_vd;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign verdict_out = vout_q;
	assign was_expired = wexp_q;

endmodule

`default_nettype wire

[src/fatc_cell.sv]
// ----------------------------------------------------------------------------
// fatc_cell
// One cache entry: takes its upper neighbour, or clears, on insert; compares on lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fatc_cell (
	input  wire              clk,
	input  wire              arst_n,
	input  fatc_pkg::ctrl_t  ctrl,
	input  wire              clr,
	input  fatc_pkg::entry_t nxt,
	input  fatc_pkg::key_t   key,
	output fatc_pkg::entry_t ent_q,
	output logic             match
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctrl.shift) begin
			ent_q <= clr ? '0 : nxt;
		end
	end

	assign match = ctrl.cmp && (ent_q.key == key);

endmodule

`default_nettype wire

[src/fatc_chain.sv]
// ----------------------------------------------------------------------------
// fatc_chain
// Row of entry cells with a registered first-match result per group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fatc_chain #(
	parameter  int unsigned ENTRIES = 100,
	localparam int unsigned NGRP    = (ENTRIES + fatc_pkg::GROUP - 1) / fatc_pkg::GROUP
) (
	input  wire              clk,
	input  wire              arst_n,
	input  fatc_pkg::ctrl_t  ctrl,
	input  fatc_pkg::entry_t new_ent,
	input  fatc_pkg::key_t   key,
	output logic [NGRP-1:0]  grp_hit_q,
	output logic [NGRP-1:0]  grp_vd_q
);

	localparam int unsigned PADW = NGRP * fatc_pkg::GROUP;

	fatc_pkg::entry_t     ent [ENTRIES];
	logic [ENTRIES-1:0]   match;
	logic [PADW-1:0]      match_pad;
	logic [PADW-1:0]      vd_pad;
	logic [NGRP-1:0]      grp_hit_d;
	logic [NGRP-1:0]      grp_vd_d;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_last
			fatc_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.clr   (1'b0),
				.nxt   (new_ent),
				.key   (key),
				.ent_q (ent[i]),
				.match (match[i])
			);
		end else begin : g_mid
			fatc_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.clr   (ctrl.clear),
				.nxt   (ent[i+1]),
				.key   (key),
				.ent_q (ent[i]),
				.match (match[i])
			);
		end
	end

	always_comb begin
		match_pad = '0;
		vd_pad    = '0;
		match_pad[ENTRIES-1:0] = match;
		for (int i = 0; i < int'(ENTRIES); i++) begin
			vd_pad[i] = ent[i].verdict;
		end
	end

	// lowest match wins inside each group
	always_comb begin
		grp_hit_d = '0;
		grp_vd_d  = '0;
		for (int g = 0; g < int'(NGRP); g++) begin
			for (int j = int'(fatc_pkg::GROUP) - 1; j >= 0; j--) begin
				if (match_pad[g * int'(fatc_pkg::GROUP) + j]) begin
					grp_hit_d[g] = 1'b1;
					grp_vd_d[g]  = vd_pad[g * int'(fatc_pkg::GROUP) + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			grp_hit_q <= grp_hit_d;
			grp_vd_q  <= grp_vd_d;
		end
	end

endmodule

`default_nettype wire

[src/fatc_checker.sv]
// ----------------------------------------------------------------------------
// fatc_checker
// Port-level checks on the authorisation cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_auth_cache_with_ttl_top_assert.svh"

module fatc_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire hit,
	input wire was_expired
);

	`FATC_ASSERT_NOW(a_hit_unexpired, out_valid && hit, !was_expired, "hit in expired bucket")
	`FATC_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")
	`FATC_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall), "result without item")
	`FATC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind fifo_auth_cache_with_ttl_top fatc_checker u_fatc_checker (.*);

`default_nettype wire

[tb/sv/tb_fifo_auth_cache_with_ttl_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_auth_cache_with_ttl_top
// Drives lookups and inserts into the authorisation cache bucket, predicts
// hit, verdict and expiry for every accepted item with a shadow of the
// bucket or a typed-in answer, and compares each output item in order.
// A short directed table comes first. Random traffic follows, with several
// TTL settings and idling on both sides.
// ----------------------------------------------------------------------------

module tb_fifo_auth_cache_with_ttl_top;

	localparam int unsigned ENTRIES = 100;
	localparam int unsigned KEYS    = 32;
	localparam int unsigned LIMIT   = 200000;

	typedef struct packed {
		logic hit;
		logic verdict;
		logic expired;
	} answer_t;

	typedef struct {
		logic        op;
		logic [31:0] bank;
		logic [63:0] acct;
		logic        vin;
		logic [31:0] stamp;
		bit          fixed;
		answer_t     ans;
	} row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic        cmd            = fatc_pkg::CMD_LOOKUP;
	logic [31:0] bank_code      = '0;
	logic [63:0] account_number = '0;
	logic        verdict_in     = 1'b0;
	logic [31:0] now_seconds    = '0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic        hit;
	logic        verdict_out;
	logic        was_expired;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [31:0] ttl_value      = fatc_pkg::TTL_RESET;

	// typed-in answer travelling with the item
	bit          row_fixed  = 1'b0;
	answer_t     row_answer = '0;

	// shadow bucket
	logic [31:0] cache_bank [ENTRIES];
	logic [63:0] cache_acct [ENTRIES];
	logic        cache_verdict [ENTRIES];
	logic [31:0] cache_stamp;
	logic [31:0] cache_ttl;

	answer_t     pending_answers [$];
	int          mismatches  = 0;
	int unsigned cycles      = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	logic [31:0] ttl_setting = fatc_pkg::TTL_RESET;
	logic [31:0] clock_now   = 32'd20000;
	logic [31:0] pool_bank [KEYS];
	logic [63:0] pool_acct [KEYS];
	row_t        directed [$];

	fifo_auth_cache_with_ttl_top #(.ENTRIES(ENTRIES)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.bank_code      (bank_code),
		.account_number (account_number),
		.verdict_in     (verdict_in),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.hit            (hit),
		.verdict_out    (verdict_out),
		.was_expired    (was_expired),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.ttl_seconds    (ttl_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_fifo_auth_cache_with_ttl_top: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
	end

	function automatic row_t mk_row(logic op, logic [31:0] b, logic [63:0] a, logic v,
			logic [31:0] n, bit fixed, answer_t ans);
		row_t r;
		r.op    = op;
		r.bank  = b;
		r.acct  = a;
		r.vin   = v;
		r.stamp = n;
		r.fixed = fixed;
		r.ans   = ans;
		return r;
	endfunction

	task automatic resolve_access(input logic op, input logic [31:0] b, input logic [63:0] a,
			input logic v, input logic [31:0] n, output answer_t ans);
		logic [31:0] age;
		bit          stale;
		age   = n - cache_stamp;
		stale = (cache_stamp == 32'd0) || (age > cache_ttl);
		ans   = '0;
		ans.expired = stale;
		if (op == fatc_pkg::CMD_LOOKUP) begin
			if (!stale) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (cache_bank[i] == b && cache_acct[i] == a) begin
						ans.hit     = 1'b1;
						ans.verdict = cache_verdict[i];
						cache_stamp = n;
						break;
					end
				end
			end
		end else begin
			for (int i = 0; i < ENTRIES - 1; i++) begin
				cache_bank[i]    = stale ? 32'd0 : cache_bank[i + 1];
				cache_acct[i]    = stale ? 64'd0 : cache_acct[i + 1];
				cache_verdict[i] = stale ? 1'b0 : cache_verdict[i + 1];
			end
			cache_bank[ENTRIES - 1]    = b;
			cache_acct[ENTRIES - 1]    = a;
			cache_verdict[ENTRIES - 1] = v;
			cache_stamp = n;
			ans.verdict = v;
		end
	endtask

	// shadow update and output check
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				cache_bank[i]    = '0;
				cache_acct[i]    = '0;
				cache_verdict[i] = 1'b0;
			end
			cache_stamp = '0;
			cache_ttl   = fatc_pkg::TTL_RESET;
		end else begin
			if (cfg_valid && cfg_ready)
				cache_ttl = ttl_value;
			if (in_valid && !in_stall) begin
				resolve_access(cmd, bank_code, account_number, verdict_in, now_seconds, want);
				pending_answers.push_back(row_fixed ? row_answer : want);
			end
			if (out_valid && !out_stall) begin
				got = '{hit, verdict_out, was_expired};
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: hit %b verdict %b expired %b",
							hit, verdict_out, was_expired);
				end else begin
					want = pending_answers.pop_front();
					if (got.hit !== want.hit || got.verdict !== want.verdict ||
							got.expired !== want.expired) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: hit %b/%b verdict %b/%b expired %b/%b (exp/got)",
								want.hit, got.hit, want.verdict, got.verdict,
								want.expired, got.expired);
					end
				end
			end
		end
	end

	task automatic offer_item(input logic op, input logic [31:0] b, input logic [63:0] a,
			input logic v, input logic [31:0] n, input bit fixed, input answer_t ans);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid       <= 1'b1;
		cmd            <= op;
		bank_code      <= b;
		account_number <= a;
		verdict_in     <= v;
		now_seconds    <= n;
		row_fixed      <= fixed;
		row_answer     <= ans;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_answers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_ttl(input logic [31:0] v);
		wait_quiet();
		cfg_valid <= 1'b1;
		ttl_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		ttl_setting = v;
	endtask

	task automatic random_items(input int count, input int insert_pct, input int jump_pct);
		logic        op;
		logic [31:0] b;
		logic [63:0] a;
		int          slot;
		int          r;
		for (int k = 0; k < count; k++) begin
			op   = ($urandom_range(99) < insert_pct) ? fatc_pkg::CMD_INSERT
				: fatc_pkg::CMD_LOOKUP;
			slot = $urandom_range(KEYS - 1);
			r    = $urandom_range(99);
			if (r < 3) begin
				b = '0;
				a = '0;
			end else if (r < 20) begin
				b = $urandom;
				a = {$urandom, $urandom};
				if (op == fatc_pkg::CMD_INSERT) begin
					pool_bank[slot] = b;
					pool_acct[slot] = a;
				end
			end else begin
				b = pool_bank[slot];
				a = pool_acct[slot];
			end
			if ($urandom_range(99) < jump_pct) begin
				case ($urandom_range(3))
					0: clock_now = clock_now + ttl_setting;
					1: clock_now = clock_now + ttl_setting + 32'd1;
					2: clock_now = $urandom;
					default: clock_now = '0;
				endcase
			end else begin
				clock_now = clock_now + $urandom_range(3);
			end
			offer_item(op, b, a, 1'($urandom_range(1)), clock_now, 1'b0, '0);
		end
	endtask

	initial begin
		for (int i = 0; i < KEYS; i++) begin
			pool_bank[i] = $urandom;
			pool_acct[i] = {$urandom, $urandom};
		end
		// after reset: bucket expired, zero timestamp
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, '0, '0, 1'b0, 32'd100, 1'b1,
			'{1'b0, 1'b0, 1'b1}));
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, '1, '1, 1'b1, 32'd1000, 1'b1,
			'{1'b0, 1'b1, 1'b1}));
		// age equal to ttl still live
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, '1, '1, 1'b0, 32'd6400, 1'b0, '0));
		// cleared records match key zero
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, '0, '0, 1'b0, 32'd6400, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, 32'h20202020, 64'h2020202020202020,
			1'b0, 32'd6401, 1'b0, '0));
		// miss left stamp alone, so one past ttl expires
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, '1, '1, 1'b0, 32'd11801, 1'b1,
			'{1'b0, 1'b0, 1'b1}));
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, 32'h41424344, 64'h3132333435202020,
			1'b0, 32'd11801, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, 32'h5A5A2020, 64'h3030303030303031,
			1'b1, 32'd11802, 1'b0, '0));
		// duplicate key appended again, lowest copy wins
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, 32'h41424344, 64'h3132333435202020,
			1'b1, 32'd11803, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, 32'h41424344, 64'h3132333435202020,
			1'b1, 32'd11804, 1'b0, '0));
		// time zero leaves the bucket expired
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, 32'h55555555, 64'hAAAAAAAAAAAAAAAA,
			1'b1, 32'd0, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, 32'h55555555, 64'hAAAAAAAAAAAAAAAA,
			1'b0, 32'd0, 1'b1, '{1'b0, 1'b0, 1'b1}));
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, 32'hAAAAAAAA, 64'h5555555555555555,
			1'b0, 32'hFFFFFF00, 1'b1, '{1'b0, 1'b0, 1'b1}));
		// age across the wrap
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, 32'hAAAAAAAA, 64'h5555555555555555,
			1'b0, 32'd256, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_INSERT, '0, '1, 1'b1, '1, 1'b0, '0));
		directed.push_back(mk_row(fatc_pkg::CMD_LOOKUP, '0, '1, 1'b0, '1, 1'b0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_item(directed[i].op, directed[i].bank, directed[i].acct, directed[i].vin,
				directed[i].stamp, directed[i].fixed, directed[i].ans);

		set_ttl('0);
		random_items(60, 50, 5);

		set_ttl('1);
		tx_idle_pct = 73;
		random_items(170, 70, 2);

		set_ttl($urandom_range(64, 1));
		tx_idle_pct  = 0;
		rx_stall_pct = 73;
		random_items(110, 50, 10);

		set_ttl(fatc_pkg::TTL_RESET);
		tx_idle_pct  = 25;
		rx_stall_pct = 25;
		random_items(55, 50, 8);
		wait_quiet();
		random_items(55, 50, 8);

		set_ttl($urandom);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		random_items(100, 50, 8);

		wait_quiet();
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("tb_fifo_auth_cache_with_ttl_top: clean");
		else
			$display("tb_fifo_auth_cache_with_ttl_top: errors");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/fatc_pkg.sv
src/fatc_cell.sv
src/fatc_chain.sv
src/fifo_auth_cache_with_ttl_top.sv
src/fatc_checker.sv
tb/sv/tb_fifo_auth_cache_with_ttl_top.sv
